>>> hdl/ovl_pkg.sv
`default_nettype none

package ovl_pkg;

  localparam int ACTION_W = 2;
  localparam int VALUE_W = 32;
  localparam int STATUS_W = 3;
  localparam int POS_W = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_LIST   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_FOUND     = 3'd5,
    ST_LISTED    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_LIST,
    S_LIST_HOLD,
    S_HOLD
  } state_t;

endpackage

`default_nettype wire

>>> hdl/ovl_if.sv
`default_nettype none

interface ovl_req_if;
  logic                                valid;
  logic                                ready;
  logic        [ovl_pkg::ACTION_W-1:0] action;
  logic signed [ovl_pkg::VALUE_W-1:0]  item_value;

  modport source(output valid, output action, output item_value, input ready);
  modport sink(input valid, input action, input item_value, output ready);
endinterface

interface ovl_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [ovl_pkg::STATUS_W-1:0] status;
  logic        [ovl_pkg::POS_W-1:0]    position;
  logic signed [ovl_pkg::VALUE_W-1:0]  entry_value;
  logic                                last;

  modport source(output valid, output status, output position, output entry_value,
                 output last, input ready);
  modport sink(input valid, input status, input position, input entry_value,
               input last, output ready);
endinterface

`default_nettype wire

>>> hdl/ordered_value_list.sv
// Ordered list of up to CAPACITY signed 32-bit values.
// The req channel carries one request word: an action and a value. Insert
// appends at the tail, delete removes the first equal entry and closes the
// gap, search reports the 1-based position of the first equal entry, and
// list returns every entry in order. The rsp channel returns result words of
// status, position, entry_value and last; last marks the final word of a
// request. One request is handled at a time and req.ready is high only when
// the block is idle with no result pending.
// Insert, and any request on an empty list, is answered straight from idle.
// A search or delete reads the entries in order from the first until one
// matches or the list ends; a delete then moves each later entry down one
// place. A list request gives one result word per entry and waits for each
// to be taken. The entry memory has one registered read port, and a scan
// reads one entry per cycle. The next request may be accepted in the cycle
// after the last result word is taken.
// A stalled rsp.ready simply holds the current result word and the sequencer.
// Reset empties the list; the next request may be accepted in the cycle
// after reset is released.
`default_nettype none

module ordered_value_list #(
  parameter int CAPACITY = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  ovl_req_if.sink           req,
  ovl_rsp_if.source         rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ovl_pkg::POS_W;
  localparam int VW = ovl_pkg::VALUE_W;

  logic signed [VW-1:0] mem [CAPACITY];
  logic signed [VW-1:0] rd_data;
  logic        [AW-1:0] rd_addr;
  logic        [AW-1:0] wr_addr;
  logic signed [VW-1:0] wr_data;
  logic                 we;

  ovl_pkg::state_t      state, state_next;
  logic        [AW-1:0] idx, idx_next;
  logic        [CW-1:0] count, count_next;
  ovl_pkg::action_t     act, act_next;
  logic signed [VW-1:0] val, val_next;
  logic                 out_valid, out_valid_next;
  ovl_pkg::status_t     out_status, out_status_next;
  logic        [PW-1:0] out_pos, out_pos_next;
  logic signed [VW-1:0] out_value, out_value_next;
  logic                 out_last, out_last_next;
  logic                 last_entry;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ovl_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    act        <= act_next;
    val        <= val_next;
    out_status <= out_status_next;
    out_pos    <= out_pos_next;
    out_value  <= out_value_next;
    out_last   <= out_last_next;
  end

  assign last_entry = ((CW'(idx) + CW'(1)) == count);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    count_next      = count;
    act_next        = act;
    val_next        = val;
    out_valid_next  = out_valid;
    out_status_next = out_status;
    out_pos_next    = out_pos;
    out_value_next  = out_value;
    out_last_next   = out_last;
    we              = 1'b0;
    wr_addr         = idx;
    wr_data         = rd_data;
    rd_addr         = '0;
    req.ready       = 1'b0;

    unique case (state)
      ovl_pkg::S_IDLE: begin
        req.ready = !rst;
        if (req.valid && !rst) begin
          act_next       = ovl_pkg::action_t'(req.action);
          val_next       = req.item_value;
          idx_next       = '0;
          out_pos_next   = '0;
          out_value_next = req.item_value;
          out_last_next  = 1'b1;
          unique case (ovl_pkg::action_t'(req.action))
            ovl_pkg::ACT_INSERT: begin
              out_valid_next = 1'b1;
              state_next     = ovl_pkg::S_HOLD;
              if (count >= CW'(CAPACITY)) begin
                out_status_next = ovl_pkg::ST_FULL;
              end else begin
                we              = 1'b1;
                wr_addr         = count[AW-1:0];
                wr_data         = req.item_value;
                count_next      = count + CW'(1);
                out_status_next = ovl_pkg::ST_INSERTED;
              end
            end
            ovl_pkg::ACT_DELETE, ovl_pkg::ACT_SEARCH: begin
              if (count == '0) begin
                out_valid_next  = 1'b1;
                out_status_next = (ovl_pkg::action_t'(req.action) == ovl_pkg::ACT_DELETE)
                                  ? ovl_pkg::ST_EMPTY : ovl_pkg::ST_NOT_FOUND;
                state_next      = ovl_pkg::S_HOLD;
              end else begin
                state_next = ovl_pkg::S_SCAN;
              end
            end
            ovl_pkg::ACT_LIST: begin
              if (count == '0) begin
                out_valid_next  = 1'b1;
                out_status_next = ovl_pkg::ST_EMPTY;
                out_value_next  = '0;
                state_next      = ovl_pkg::S_HOLD;
              end else begin
                state_next = ovl_pkg::S_LIST;
              end
            end
            default: begin
              state_next = ovl_pkg::S_IDLE;
            end
          endcase
        end
      end

      ovl_pkg::S_SCAN: begin
        rd_addr = idx + AW'(1);
        if (rd_data == val) begin
          if (act == ovl_pkg::ACT_DELETE) begin
            state_next = ovl_pkg::S_SHIFT;
          end else begin
            out_valid_next  = 1'b1;
            out_status_next = ovl_pkg::ST_FOUND;
            out_pos_next    = PW'(idx) + PW'(1);
            state_next      = ovl_pkg::S_HOLD;
          end
        end else if (last_entry) begin
          out_valid_next  = 1'b1;
          out_status_next = ovl_pkg::ST_NOT_FOUND;
          state_next      = ovl_pkg::S_HOLD;
        end else begin
          idx_next = idx + AW'(1);
        end
      end

      ovl_pkg::S_SHIFT: begin
        rd_addr = idx + AW'(2);
        if (last_entry) begin
          count_next      = count - CW'(1);
          out_valid_next  = 1'b1;
          out_status_next = ovl_pkg::ST_DELETED;
          state_next      = ovl_pkg::S_HOLD;
        end else begin
          we       = 1'b1;
          wr_addr  = idx;
          wr_data  = rd_data;
          idx_next = idx + AW'(1);
        end
      end

      ovl_pkg::S_LIST: begin
        rd_addr         = idx + AW'(1);
        out_valid_next  = 1'b1;
        out_status_next = ovl_pkg::ST_LISTED;
        out_pos_next    = PW'(idx) + PW'(1);
        out_value_next  = rd_data;
        out_last_next   = last_entry;
        state_next      = ovl_pkg::S_LIST_HOLD;
      end

      ovl_pkg::S_LIST_HOLD: begin
        rd_addr = idx + AW'(1);
        if (rsp.ready) begin
          out_valid_next = 1'b0;
          if (out_last) begin
            state_next = ovl_pkg::S_IDLE;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = ovl_pkg::S_LIST;
          end
        end
      end

      ovl_pkg::S_HOLD: begin
        if (rsp.ready) begin
          out_valid_next = 1'b0;
          state_next     = ovl_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ovl_pkg::S_IDLE;
      end
    endcase
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.position    = out_pos;
  assign rsp.entry_value = out_value;
  assign rsp.last        = out_last;

endmodule

`default_nettype wire

>>> hdl/ovl_checker.sv
`default_nettype none

module ovl_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_valid,
  input wire logic                         req_ready,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_ready,
  input wire logic [ovl_pkg::STATUS_W-1:0] rsp_status,
  input wire logic [ovl_pkg::POS_W-1:0]    rsp_position,
  input wire logic                         rsp_last
);

  // A pending result word stays valid, with status and position unchanged, until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_position))
    else $error("result word dropped or changed while stalled");

  // Only one request is in flight at a time.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request accepted while a result word is pending");

  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high after a request was accepted");

  // Every result other than a listed entry ends its request.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ovl_pkg::ST_LISTED) |-> rsp_last)
    else $error("single result word without last");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_position != '0) ==
                   ((rsp_status == ovl_pkg::ST_FOUND) || (rsp_status == ovl_pkg::ST_LISTED))))
    else $error("position does not agree with status");

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_position (rsp.position),
  .rsp_last     (rsp.last)
);

`default_nettype wire
